// ===== hw/rtl/bc1_bc2_bc3_block_decoder_unit_macros.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef BC1_BC2_BC3_BLOCK_DECODER_UNIT_MACROS_SVH
`define BC1_BC2_BC3_BLOCK_DECODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define BCDEC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define BCDEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BCDEC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BCDEC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/bcdec_pkg.sv =====
`default_nettype none
package bcdec_pkg;

   localparam int TEXELS      = 16;
   localparam int TEXEL_IDX_W = $clog2(TEXELS);
   localparam logic [TEXEL_IDX_W-1:0] LAST_TEXEL = TEXEL_IDX_W'(TEXELS - 1);

   localparam logic [1:0] FMT_BC1 = 2'd0;
   localparam logic [1:0] FMT_BC2 = 2'd1;
   localparam logic [1:0] FMT_BC3 = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Channel order inside an rgb value: 0 blue, 1 green, 2 red.
   typedef logic [2:0][7:0] rgb_type;

   // One fully decoded block waiting for texel output.
   typedef struct packed {
      logic [1:0]        mode;
      logic [3:0][31:0]  color_pal;
      logic [7:0][7:0]   alpha_pal;
      logic [31:0]       color_idx;
      logic [63:0]       alpha_blk;
   } block_entry_type;

   function automatic rgb_type expand565(input logic [15:0] c);
      rgb_type res;
      res[2] = {c[15:11], c[15:13]};
      res[1] = {c[10:5], c[10:9]};
      res[0] = {c[4:0], c[4:2]};
      return res;
   endfunction

   // Reciprocal multiplications, exact for the sum ranges that occur here.
   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [19:0] p;
      p = 20'(x) * 20'd683;
      return p[18:11];
   endfunction

   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [21:0] p;
      p = 22'(x) * 22'd1639;
      return p[20:13];
   endfunction

   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [22:0] p;
      p = 23'(x) * 23'd2341;
      return p[21:14];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bcdec_front.sv =====
`default_nettype none
module bcdec_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   output logic                           full,
   input  wire logic [63:0]               req_color_block,
   input  wire logic [63:0]               req_alpha_block,
   input  wire logic [1:0]                format_mode,
   input  wire logic                      q_full,
   output logic                           q_wr,
   output bcdec_pkg::block_entry_type     q_data
);

   logic                   valid_ff, valid_in;
   logic [1:0]             mode_ff;
   logic                   four_ff, alpha8_ff;
   bcdec_pkg::rgb_type     e0_ff, e1_ff, chalf_ff;
   logic [2:0][9:0]        csum2_ff, csum3_ff;
   logic [5:0][10:0]       asum_ff;
   logic [31:0]            cidx_ff;
   logic [63:0]            ablk_ff;

   logic                   accept;
   logic                   four_c, alpha8_c;
   bcdec_pkg::rgb_type     e0_c, e1_c, chalf_c;
   logic [2:0][9:0]        csum2_c, csum3_c;
   logic [5:0][10:0]       asum_c;
   logic [7:0]             a0, a1;

   assign full   = valid_ff && q_full;
   assign accept = push && !full;
   assign q_wr   = valid_ff && !q_full;

   assign a0       = req_alpha_block[7:0];
   assign a1       = req_alpha_block[15:8];
   assign alpha8_c = a0 > a1;
   assign four_c   = (format_mode == bcdec_pkg::FMT_BC2) ||
                     (format_mode == bcdec_pkg::FMT_BC3) ||
                     (req_color_block[15:0] > req_color_block[31:16]);
   assign e0_c     = bcdec_pkg::expand565(req_color_block[15:0]);
   assign e1_c     = bcdec_pkg::expand565(req_color_block[31:16]);

   // Weighted endpoint sums; the divisions follow in the next cycle.
   always_comb begin
      logic [2:0]  w0, w1;
      logic [8:0]  hsum;
      for (int ch = 0; ch < 3; ch++) begin
         csum2_c[ch] = {1'b0, e0_c[ch], 1'b0} + 10'(e1_c[ch]);
         csum3_c[ch] = 10'(e0_c[ch]) + {1'b0, e1_c[ch], 1'b0};
         hsum        = 9'(e0_c[ch]) + 9'(e1_c[ch]);
         chalf_c[ch] = hsum[8:1];
      end
      for (int k = 1; k <= 6; k++) begin
         if (alpha8_c) begin
            w0 = 3'(7 - k);
            w1 = 3'(k);
         end else if (k <= 4) begin
            w0 = 3'(5 - k);
            w1 = 3'(k);
         end else begin
            w0 = 3'd0;
            w1 = 3'd0;
         end
         asum_c[k-1] = 11'(w0) * 11'(a0) + 11'(w1) * 11'(a1);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_wr) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= format_mode;
         four_ff   <= four_c;
         alpha8_ff <= alpha8_c;
         e0_ff     <= e0_c;
         e1_ff     <= e1_c;
         chalf_ff  <= chalf_c;
         csum2_ff  <= csum2_c;
         csum3_ff  <= csum3_c;
         asum_ff   <= asum_c;
         cidx_ff   <= req_color_block[63:32];
         ablk_ff   <= req_alpha_block;
      end
   end

   // Palette construction for the queue entry.
   always_comb begin
      q_data.mode      = mode_ff;
      q_data.color_idx = cidx_ff;
      q_data.alpha_blk = ablk_ff;
      q_data.color_pal[0] = {8'hFF, e0_ff[2], e0_ff[1], e0_ff[0]};
      q_data.color_pal[1] = {8'hFF, e1_ff[2], e1_ff[1], e1_ff[0]};
      if (four_ff) begin
         q_data.color_pal[2] = {8'hFF, bcdec_pkg::div3(csum2_ff[2]),
                                bcdec_pkg::div3(csum2_ff[1]), bcdec_pkg::div3(csum2_ff[0])};
         q_data.color_pal[3] = {8'hFF, bcdec_pkg::div3(csum3_ff[2]),
                                bcdec_pkg::div3(csum3_ff[1]), bcdec_pkg::div3(csum3_ff[0])};
      end else begin
         // Three-color mode: the last entry is transparent black.
         q_data.color_pal[2] = {8'hFF, chalf_ff[2], chalf_ff[1], chalf_ff[0]};
         q_data.color_pal[3] = 32'h0000_0000;
      end
      q_data.alpha_pal[0] = ablk_ff[7:0];
      q_data.alpha_pal[1] = ablk_ff[15:8];
      for (int k = 1; k <= 6; k++) begin
         if (alpha8_ff) begin
            q_data.alpha_pal[k+1] = bcdec_pkg::div7(asum_ff[k-1]);
         end else if (k <= 4) begin
            q_data.alpha_pal[k+1] = bcdec_pkg::div5(asum_ff[k-1]);
         end else if (k == 5) begin
            q_data.alpha_pal[k+1] = 8'h00;
         end else begin
            q_data.alpha_pal[k+1] = 8'hFF;
         end
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/bcdec_queue.sv =====
`default_nettype none
module bcdec_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      wr_en,
   input  wire bcdec_pkg::block_entry_type wr_data,
   output logic                           q_full,
   input  wire logic                      rd_en,
   output bcdec_pkg::block_entry_type     rd_data,
   output logic                           q_empty
);

   bcdec_pkg::block_entry_type                   mem_ff [bcdec_pkg::QUEUE_DEPTH];
   logic [bcdec_pkg::QUEUE_PTR_W-1:0]            wr_ptr_ff, wr_ptr_in;
   logic [bcdec_pkg::QUEUE_PTR_W-1:0]            rd_ptr_ff, rd_ptr_in;
   logic [bcdec_pkg::QUEUE_CNT_W-1:0]            count_ff, count_in;
   logic                                         do_wr, do_rd;

   localparam logic [bcdec_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      bcdec_pkg::QUEUE_PTR_W'(bcdec_pkg::QUEUE_DEPTH - 1);
   localparam logic [bcdec_pkg::QUEUE_CNT_W-1:0] CNT_MAX =
      bcdec_pkg::QUEUE_CNT_W'(bcdec_pkg::QUEUE_DEPTH);

   assign q_full  = count_ff == CNT_MAX;
   assign q_empty = count_ff == '0;
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/bcdec_back.sv =====
`default_nettype none
module bcdec_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 q_empty,
   input  wire bcdec_pkg::block_entry_type           q_data,
   output logic                                      q_rd,
   input  wire logic                                 pop,
   output logic                                      empty,
   output logic [31:0]                               rsp_texel_bgra,
   output logic [3:0]                                rsp_texel_index,
   output logic                                      rsp_last_texel
);

   logic [bcdec_pkg::TEXEL_IDX_W-1:0] cnt_ff, cnt_in;
   logic                              out_valid_ff, out_valid_in;
   logic [31:0]                       bgra_ff, bgra_in;
   logic [3:0]                        index_ff;
   logic                              last_ff;
   logic                              advance;
   logic [1:0]                        ci;
   logic [3:0]                        nib;
   logic [2:0]                        ai;
   logic [31:0]                       base;

   assign advance = !q_empty && (!out_valid_ff || pop);
   assign q_rd    = advance && (cnt_ff == bcdec_pkg::LAST_TEXEL);

   assign ci   = q_data.color_idx[{cnt_ff, 1'b0} +: 2];
   assign nib  = q_data.alpha_blk[{cnt_ff, 2'b00} +: 4];
   assign ai   = q_data.alpha_blk[6'(cnt_ff) * 6'd3 + 6'd16 +: 3];
   assign base = q_data.color_pal[ci];

   always_comb begin
      unique case (q_data.mode)
         bcdec_pkg::FMT_BC2: bgra_in = {nib, nib, base[23:0]};
         bcdec_pkg::FMT_BC3: bgra_in = {q_data.alpha_pal[ai], base[23:0]};
         default:            bgra_in = base;
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         cnt_in       = cnt_ff + 1'b1;
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bgra_ff  <= bgra_in;
         index_ff <= 4'(cnt_ff);
         last_ff  <= cnt_ff == bcdec_pkg::LAST_TEXEL;
      end
   end

   assign empty           = !out_valid_ff;
   assign rsp_texel_bgra  = bgra_ff;
   assign rsp_texel_index = index_ff;
   assign rsp_last_texel  = last_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/bc1_bc2_bc3_block_decoder_unit.sv =====
`default_nettype none
// Decodes one BC1, BC2 or BC3 (DXT1/3/5) 4x4 block per transaction into sixteen BGRA8 texels
// delivered in raster order, the sixteenth flagged by rsp_last_texel. The texel output
// stage emits one texel per cycle while a block is queued and the output is empty or popped,
// and the front end accepts new blocks while earlier ones are still being output. The first
// texel of a block passes the front-end registers, the queue and the output register.
// A front end expands endpoints and registers the palette sums, then builds both palettes;
// a two-entry queue of decoded blocks lets it run ahead of the output. The format register
// is sampled when a block is accepted and should be written only while no block is in flight.
`include "bc1_bc2_bc3_block_decoder_unit_macros.svh"
module bc1_bc2_bc3_block_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [63:0] req_color_block,
   input  wire logic [63:0] req_alpha_block,
   output logic             empty,
   input  wire logic        pop,
   output logic [31:0]      rsp_texel_bgra,
   output logic [3:0]       rsp_texel_index,
   output logic             rsp_last_texel,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_write_data
);

   logic [1:0]                   format_mode_q_ff;
   logic                         q_wr, q_full, q_rd, q_empty;
   bcdec_pkg::block_entry_type   q_wr_data, q_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_mode_q_ff <= bcdec_pkg::FMT_BC1;
      end else if (csr_write_enable) begin
         format_mode_q_ff <= csr_write_data;
      end
   end

   bcdec_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_color_block (req_color_block),
      .req_alpha_block (req_alpha_block),
      .format_mode     (format_mode_q_ff),
      .q_full          (q_full),
      .q_wr            (q_wr),
      .q_data          (q_wr_data)
   );

   bcdec_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr),
      .wr_data (q_wr_data),
      .q_full  (q_full),
      .rd_en   (q_rd),
      .rd_data (q_rd_data),
      .q_empty (q_empty)
   );

   bcdec_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (q_rd_data),
      .q_rd            (q_rd),
      .pop             (pop),
      .empty           (empty),
      .rsp_texel_bgra  (rsp_texel_bgra),
      .rsp_texel_index (rsp_texel_index),
      .rsp_last_texel  (rsp_last_texel)
   );

   `BCDEC_ASSERT_IMPL(a_last_flag, clock, reset, !empty,
      rsp_last_texel == (rsp_texel_index == bcdec_pkg::LAST_TEXEL))
   `BCDEC_ASSERT_NEXT(a_texel_order, clock, reset, !empty && pop && !rsp_last_texel,
      !empty && (rsp_texel_index == 4'($past(rsp_texel_index) + 4'd1)))
   `BCDEC_ASSERT_IMPL(a_no_queue_overflow, clock, reset, q_wr, !q_full)
   `BCDEC_ASSERT_IMPL(a_full_needs_queue_full, clock, reset, full, q_full)

endmodule
`default_nettype wire
